[rtl/core/mapping_inverse_bisection_defines.svh]
// assertion macros for the mapping inverse bisection block
// sampled on clk_i, disabled while rst_ni is low; no other dependencies
`ifndef MAPPING_INVERSE_BISECTION_DEFINES_SVH
`define MAPPING_INVERSE_BISECTION_DEFINES_SVH

// plain property check
`define MIB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication check
`define MIB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/mib_pkg.sv]
// shared widths, constants and types of the mapping inverse bisection block
// used by mib_mul_round and mapping_inverse_bisection; no dependencies
`default_nettype none

package mib_pkg;

  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int FRAC_BITS  = 24;
  localparam int XI_W       = FRAC_BITS + 2;
  localparam int POLY_W     = FRAC_BITS + 4;
  localparam int RND_W      = PROD_W - FRAC_BITS;
  localparam int Y_W        = RND_W + 1;
  localparam int ACC_W      = RND_W + 2;
  localparam int RES_W      = Y_W + 1;
  localparam int ZONE_W     = 4;
  localparam int ZC_W       = 5;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [ZC_W-1:0]    MAX_ZONES      = ZC_W'(16);
  localparam logic [ZC_W-1:0]    ZONE_COUNT_RST = ZC_W'(2);
  localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST = LIMIT_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(1);

  localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(1) <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] TWO_Q   = DATA_W'(2) <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] THREE_Q = DATA_W'(3) <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] FIVE_Q  = DATA_W'(5) <<< FRAC_BITS;

  localparam logic signed [XI_W-1:0] XI_ONE     = XI_W'(1) <<< FRAC_BITS;
  localparam logic signed [XI_W-1:0] XI_NEG_ONE = -XI_ONE;

  typedef enum logic [1:0] {
    RND_SHIFT_24,
    RND_SHIFT_25,
    RND_SHIFT_26
  } rnd_shift_e;

  typedef enum logic [1:0] {
    KIND_KERNEL,
    KIND_SHELL,
    KIND_OUTER
  } zone_kind_e;

  typedef struct packed {
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    rnd_shift_e        shift;
  } mul_req_t;

endpackage

`default_nettype wire

[rtl/core/mib_mul_round.sv]
// shared signed multiplier with registered product and rounding right shift
// depends on mib_pkg for widths, shift codes and the request struct
`default_nettype none

module mib_mul_round (
  input  wire logic                            clk_i,
  input  wire logic                            load_i,
  input  wire mib_pkg::mul_req_t               req_i,
  output logic signed [mib_pkg::RND_W-1:0]     rnd_o
);

  localparam int EXT_W = mib_pkg::PROD_W + 1;
  localparam logic signed [EXT_W-1:0] HALF_24 = EXT_W'(1) <<< (mib_pkg::FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] HALF_25 = EXT_W'(1) <<< mib_pkg::FRAC_BITS;
  localparam logic signed [EXT_W-1:0] HALF_26 = EXT_W'(1) <<< (mib_pkg::FRAC_BITS + 1);

  logic signed [mib_pkg::PROD_W-1:0] prod_q;
  logic signed [mib_pkg::PROD_W-1:0] prod_d;
  mib_pkg::rnd_shift_e               shift_q;
  logic signed [EXT_W-1:0]           ext;
  logic signed [EXT_W-1:0]           shifted;

  assign prod_d = mib_pkg::PROD_W'($signed(req_i.op_a)) *
                  mib_pkg::PROD_W'($signed(req_i.op_b));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q  <= prod_d;
      shift_q <= req_i.shift;
    end
  end

  // round to nearest, ties toward plus infinity
  always_comb begin
    ext = $signed({prod_q[mib_pkg::PROD_W-1], prod_q});
    case (shift_q)
      mib_pkg::RND_SHIFT_24: shifted = (ext + HALF_24) >>> mib_pkg::FRAC_BITS;
      mib_pkg::RND_SHIFT_25: shifted = (ext + HALF_25) >>> (mib_pkg::FRAC_BITS + 1);
      mib_pkg::RND_SHIFT_26: shifted = (ext + HALF_26) >>> (mib_pkg::FRAC_BITS + 2);
      default:               shifted = (ext + HALF_24) >>> mib_pkg::FRAC_BITS;
    endcase
  end

  assign rnd_o = shifted[mib_pkg::RND_W-1:0];

endmodule

`default_nettype wire

[rtl/core/mapping_inverse_bisection.sv]
// Bisection inverse of a zone's radial mapping polynomial in signed Q8.24. One input
// transaction gives zone, alpha, beta, f, g and the target; one output transaction returns
// the last bracket midpoint and a flag set when the iteration limit ran out first. Work runs
// on one shared 32x32 multiplier under a small sequencer: every multiply is issued, then
// rounded and written back, and each polynomial evaluation ends with a residual step; an
// evaluation uses eight multiplies in the kernel, five in a shell and four in the outer zone.
// A search evaluates the start point and then n bisection steps (24 in the kernel and 25
// elsewhere when converging, at most iteration_limit), each evaluating the new midpoint.
// Input ready is high only while idle; a finished result waits in the output register.
// Configuration writes are always taken and must only happen while the block is idle.
// Depends on mib_pkg, mib_mul_round and mapping_inverse_bisection_defines.svh.
`default_nettype none

`include "mapping_inverse_bisection_defines.svh"

module mapping_inverse_bisection (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [mib_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [mib_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [mib_pkg::ZONE_W-1:0]           zone_i,
  input  wire logic signed [mib_pkg::DATA_W-1:0]    scale_alpha_i,
  input  wire logic signed [mib_pkg::DATA_W-1:0]    offset_beta_i,
  input  wire logic signed [mib_pkg::DATA_W-1:0]    inner_shape_i,
  input  wire logic signed [mib_pkg::DATA_W-1:0]    outer_shape_i,
  input  wire logic signed [mib_pkg::DATA_W-1:0]    target_radius_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [mib_pkg::XI_W-1:0]           xi_root_o,
  output logic                                      limit_hit_o
);

  localparam int DW = mib_pkg::DATA_W;
  localparam int XW = mib_pkg::XI_W;
  localparam int PW = mib_pkg::POLY_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WB    = 3'd2;
  localparam logic [2:0] ST_RESID = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [2:0] OP_X2  = 3'd0;
  localparam logic [2:0] OP_X3  = 3'd1;
  localparam logic [2:0] OP_X4  = 3'd2;
  localparam logic [2:0] OP_CFK = 3'd3;
  localparam logic [2:0] OP_CGK = 3'd4;
  localparam logic [2:0] OP_TF  = 3'd5;
  localparam logic [2:0] OP_TG  = 3'd6;
  localparam logic [2:0] OP_Y   = 3'd7;

  localparam logic signed [XW:0] WIDTH_ONE = (XW + 1)'(1);

  function automatic logic [2:0] next_op(input logic [2:0] op,
                                         input mib_pkg::zone_kind_e kind);
    logic [2:0] nxt;
    case (op)
      OP_X2:   nxt = OP_X3;
      OP_X3:   nxt = (kind == mib_pkg::KIND_KERNEL) ? OP_X4 : OP_TF;
      OP_X4:   nxt = OP_CFK;
      OP_CFK:  nxt = OP_CGK;
      OP_CGK:  nxt = OP_TF;
      OP_TF:   nxt = (kind == mib_pkg::KIND_OUTER) ? OP_Y : OP_TG;
      OP_TG:   nxt = OP_Y;
      default: nxt = OP_X2;
    endcase
    return nxt;
  endfunction

  // control state
  logic [2:0]                   state_q, state_d;
  logic [2:0]                   op_q, op_d;
  logic [mib_pkg::LIMIT_W-1:0]  iter_q, iter_d;
  logic                         first_q, first_d;
  logic                         done_q, done_d;
  mib_pkg::zone_kind_e          kind_q, kind_d;
  logic                         out_valid_q, out_valid_d;
  logic [mib_pkg::ZC_W-1:0]     zone_count_q;
  logic [mib_pkg::LIMIT_W-1:0]  iter_limit_q;

  // datapath
  logic signed [XW-1:0]              low_q, low_d, high_q, high_d, x_q, x_d;
  logic                              ylow_neg_q, ylow_neg_d, ylow_zero_q, ylow_zero_d;
  logic signed [PW-1:0]              x2_q, x2_d, x3_q, x3_d, x4_q, x4_d;
  logic signed [PW-1:0]              cf_q, cf_d, cg_q, cg_d;
  logic signed [mib_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [mib_pkg::Y_W-1:0]    y_q, y_d;
  logic signed [DW-1:0]              al_q, al_d, be_q, be_d, f_q, f_d, g_q, g_d, r_q, r_d;
  logic signed [XW-1:0]              xi_root_q, xi_root_d;
  logic                              limit_hit_q, limit_hit_d;

  logic                              mul_load;
  mib_pkg::mul_req_t                 mul_req;
  logic signed [mib_pkg::RND_W-1:0]  rnd;

  logic signed [DW-1:0]              x_ext, x2_ext, x3_ext, x4_ext, cf_ext, cg_ext;
  logic signed [DW-1:0]              cf_shell, cg_shell, cfk_b, cgk_b, acc_sat;
  logic signed [mib_pkg::ACC_W-1:0]  rnd_acc, acc_base;
  logic signed [mib_pkg::RES_W-1:0]  res;
  logic                              res_neg, res_zero, brk;
  logic signed [XW-1:0]              new_low, new_high, next_mid;
  logic signed [XW:0]                mid_sum, width;
  logic [mib_pkg::ZC_W-1:0]          zc_clamp;
  mib_pkg::zone_kind_e               in_kind;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign xi_root_o   = xi_root_q;
  assign limit_hit_o = limit_hit_q;

  // zone classification
  always_comb begin
    zc_clamp = (zone_count_q > mib_pkg::MAX_ZONES) ? mib_pkg::MAX_ZONES : zone_count_q;
    if (zone_i == '0) begin
      in_kind = mib_pkg::KIND_KERNEL;
    end else if ((mib_pkg::ZC_W'(zone_i) + mib_pkg::ZC_W'(1)) < zc_clamp) begin
      in_kind = mib_pkg::KIND_SHELL;
    end else begin
      in_kind = mib_pkg::KIND_OUTER;
    end
  end

  // operand selection for the shared multiplier
  assign x_ext  = {{(DW-XW){x_q[XW-1]}}, x_q};
  assign x2_ext = {{(DW-PW){x2_q[PW-1]}}, x2_q};
  assign x3_ext = {{(DW-PW){x3_q[PW-1]}}, x3_q};
  assign x4_ext = {{(DW-PW){x4_q[PW-1]}}, x4_q};
  assign cf_ext = {{(DW-PW){cf_q[PW-1]}}, cf_q};
  assign cg_ext = {{(DW-PW){cg_q[PW-1]}}, cg_q};

  assign cf_shell = x3_ext - x_ext - (x_ext <<< 1) + mib_pkg::TWO_Q;
  assign cg_shell = mib_pkg::TWO_Q - x3_ext + x_ext + (x_ext <<< 1);
  assign cfk_b    = mib_pkg::THREE_Q - (x2_ext <<< 1);
  assign cgk_b    = mib_pkg::FIVE_Q - x2_ext - (x2_ext <<< 1);

  always_comb begin
    if ((&acc_q[mib_pkg::ACC_W-1:DW-1]) || !(|acc_q[mib_pkg::ACC_W-1:DW-1])) begin
      acc_sat = acc_q[DW-1:0];
    end else if (acc_q[mib_pkg::ACC_W-1]) begin
      acc_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_comb begin
    mul_req.op_a  = x_ext;
    mul_req.op_b  = x_ext;
    mul_req.shift = mib_pkg::RND_SHIFT_24;
    case (op_q)
      OP_X2: begin
        mul_req.op_a = x_ext;
        mul_req.op_b = x_ext;
      end
      OP_X3: begin
        mul_req.op_a = x2_ext;
        mul_req.op_b = x_ext;
      end
      OP_X4: begin
        mul_req.op_a = x2_ext;
        mul_req.op_b = x2_ext;
      end
      OP_CFK: begin
        mul_req.op_a = x4_ext;
        mul_req.op_b = cfk_b;
      end
      OP_CGK: begin
        mul_req.op_a = x3_ext;
        mul_req.op_b = cgk_b;
      end
      OP_TF: begin
        mul_req.op_b = f_q;
        if (kind_q == mib_pkg::KIND_KERNEL) begin
          mul_req.op_a = cf_ext;
        end else begin
          mul_req.op_a  = cf_shell;
          mul_req.shift = mib_pkg::RND_SHIFT_26;
        end
      end
      OP_TG: begin
        mul_req.op_b = g_q;
        if (kind_q == mib_pkg::KIND_KERNEL) begin
          mul_req.op_a  = cg_ext;
          mul_req.shift = mib_pkg::RND_SHIFT_25;
        end else begin
          mul_req.op_a  = cg_shell;
          mul_req.shift = mib_pkg::RND_SHIFT_26;
        end
      end
      OP_Y: begin
        mul_req.op_a = al_q;
        mul_req.op_b = acc_sat;
      end
      default: begin
        mul_req.op_a = x_ext;
      end
    endcase
  end

  mib_mul_round u_mul (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .req_i  (mul_req),
    .rnd_o  (rnd)
  );

  // write-back and bracket update helpers
  assign rnd_acc  = {{(mib_pkg::ACC_W-mib_pkg::RND_W){rnd[mib_pkg::RND_W-1]}}, rnd};
  assign acc_base = (kind_q == mib_pkg::KIND_OUTER)
                  ? mib_pkg::ACC_W'(x_ext) - mib_pkg::ACC_W'(mib_pkg::ONE_Q)
                  : mib_pkg::ACC_W'(x_ext);

  assign res      = {y_q[mib_pkg::Y_W-1], y_q} - mib_pkg::RES_W'(r_q);
  assign res_neg  = res[mib_pkg::RES_W-1];
  assign res_zero = (res == '0);
  assign brk      = ylow_zero_q || res_zero || (ylow_neg_q != res_neg);

  always_comb begin
    if (first_q) begin
      new_low  = low_q;
      new_high = high_q;
    end else if (brk) begin
      new_low  = low_q;
      new_high = x_q;
    end else begin
      new_low  = x_q;
      new_high = high_q;
    end
  end

  assign mid_sum  = {new_low[XW-1], new_low} + {new_high[XW-1], new_high};
  assign next_mid = mid_sum[XW:1];
  assign width    = {new_high[XW-1], new_high} - {new_low[XW-1], new_low};

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    iter_d      = iter_q;
    first_d     = first_q;
    done_d      = done_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q;
    low_d       = low_q;
    high_d      = high_q;
    x_d         = x_q;
    ylow_neg_d  = ylow_neg_q;
    ylow_zero_d = ylow_zero_q;
    x2_d        = x2_q;
    x3_d        = x3_q;
    x4_d        = x4_q;
    cf_d        = cf_q;
    cg_d        = cg_q;
    acc_d       = acc_q;
    y_d         = y_q;
    al_d        = al_q;
    be_d        = be_q;
    f_d         = f_q;
    g_d         = g_q;
    r_d         = r_q;
    xi_root_d   = xi_root_q;
    limit_hit_d = limit_hit_q;
    mul_load    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          al_d    = scale_alpha_i;
          be_d    = offset_beta_i;
          f_d     = inner_shape_i;
          g_d     = outer_shape_i;
          r_d     = target_radius_i;
          kind_d  = in_kind;
          low_d   = (in_kind == mib_pkg::KIND_KERNEL) ? '0 : mib_pkg::XI_NEG_ONE;
          high_d  = mib_pkg::XI_ONE;
          x_d     = (in_kind == mib_pkg::KIND_KERNEL) ? '0 : mib_pkg::XI_NEG_ONE;
          first_d = 1'b1;
          iter_d  = '0;
          op_d    = OP_X2;
          done_d  = 1'b0;
          if (iter_limit_q == '0) begin
            x_d     = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        mul_load = 1'b1;
        state_d  = ST_WB;
      end
      ST_WB: begin
        case (op_q)
          OP_X2:   x2_d  = rnd[PW-1:0];
          OP_X3:   x3_d  = rnd[PW-1:0];
          OP_X4:   x4_d  = rnd[PW-1:0];
          OP_CFK:  cf_d  = rnd[PW-1:0];
          OP_CGK:  cg_d  = rnd[PW-1:0];
          OP_TF:   acc_d = acc_base + rnd_acc;
          OP_TG:   acc_d = acc_q + rnd_acc;
          default: begin
            y_d = mib_pkg::Y_W'(rnd) +
                  ((kind_q == mib_pkg::KIND_SHELL) ? mib_pkg::Y_W'(be_q) : '0);
          end
        endcase
        op_d    = next_op(op_q, kind_q);
        state_d = (op_q == OP_Y) ? ST_RESID : ST_ISSUE;
      end
      ST_RESID: begin
        op_d = OP_X2;
        if (first_q) begin
          ylow_neg_d  = res_neg;
          ylow_zero_d = res_zero;
          first_d     = 1'b0;
          iter_d      = mib_pkg::LIMIT_W'(1);
          x_d         = next_mid;
          state_d     = ST_ISSUE;
        end else begin
          low_d  = new_low;
          high_d = new_high;
          if (!brk) begin
            ylow_neg_d  = res_neg;
            ylow_zero_d = res_zero;
          end
          if (width <= WIDTH_ONE) begin
            done_d  = 1'b1;
            state_d = ST_OUT;
          end else if (iter_q == iter_limit_q) begin
            state_d = ST_OUT;
          end else begin
            iter_d  = iter_q + mib_pkg::LIMIT_W'(1);
            x_d     = next_mid;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          xi_root_d   = x_q;
          limit_hit_d = ~done_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_X2;
      iter_q       <= '0;
      first_q      <= 1'b0;
      done_q       <= 1'b0;
      kind_q       <= mib_pkg::KIND_KERNEL;
      out_valid_q  <= 1'b0;
      zone_count_q <= mib_pkg::ZONE_COUNT_RST;
      iter_limit_q <= mib_pkg::ITER_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      iter_q      <= iter_d;
      first_q     <= first_d;
      done_q      <= done_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mib_pkg::REG_ZONE_COUNT: zone_count_q <= cfg_data_i[mib_pkg::ZC_W-1:0];
          mib_pkg::REG_ITER_LIMIT: iter_limit_q <= cfg_data_i[mib_pkg::LIMIT_W-1:0];
          default:                 iter_limit_q <= iter_limit_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    low_q       <= low_d;
    high_q      <= high_d;
    x_q         <= x_d;
    ylow_neg_q  <= ylow_neg_d;
    ylow_zero_q <= ylow_zero_d;
    x2_q        <= x2_d;
    x3_q        <= x3_d;
    x4_q        <= x4_d;
    cf_q        <= cf_d;
    cg_q        <= cg_d;
    acc_q       <= acc_d;
    y_q         <= y_d;
    al_q        <= al_d;
    be_q        <= be_d;
    f_q         <= f_d;
    g_q         <= g_d;
    r_q         <= r_d;
    xi_root_q   <= xi_root_d;
    limit_hit_q <= limit_hit_d;
  end

  `MIB_ASSERT_IMPL(a_bracket_order, state_q != ST_IDLE, low_q < high_q, "bracket collapsed")
  `MIB_ASSERT_IMPL(a_mid_in_bracket, state_q == ST_ISSUE, (x_q >= low_q) && (x_q <= high_q), "midpoint outside bracket")
  `MIB_ASSERT_IMPL(a_iter_bound, state_q != ST_IDLE, iter_q <= iter_limit_q, "step count beyond limit")
  `MIB_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> ($past(state_q) == ST_OUT), "result without finished search")

endmodule

`default_nettype wire
